// ===== hdl/duration_string_parser_assert.svh =====
// Assertion macros for the duration string parser.
// Needs clk and arst_n in the scope where they are used.
`ifndef DURATION_STRING_PARSER_ASSERT_SVH
`define DURATION_STRING_PARSER_ASSERT_SVH

// same-cycle implication, quiet during reset
`define DSP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, quiet during reset
`define DSP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/dsp_pkg.sv =====
// Package for the duration string parser: widths, character codes,
// unit codes and the seconds-per-unit table. No dependencies.
`timescale 1ns / 1ps

package dsp_pkg;

	localparam int CharW  = 16;
	localparam int PendW  = 31;
	localparam int TotalW = 63;
	localparam int FactW  = 17;
	localparam int ProdW  = PendW + FactW;

	localparam logic [PendW-1:0]  PEND_MAX  = '1;
	localparam logic [TotalW-1:0] TOTAL_MAX = '1;

	localparam logic [CharW-1:0] CH_ZERO = 16'h0030;
	localparam logic [CharW-1:0] CH_NINE = 16'h0039;
	localparam logic [CharW-1:0] CH_DOT  = 16'h002E;
	localparam logic [CharW-1:0] CH_D    = 16'h0044;
	localparam logic [CharW-1:0] CH_H    = 16'h0048;
	localparam logic [CharW-1:0] CH_M    = 16'h004D;
	localparam logic [CharW-1:0] CH_S    = 16'h0053;

	localparam int SecsPerMin  = 60;
	localparam int SecsPerHour = 3600;
	localparam int HoursPerDay = 24;
	localparam int SecsPerDay  = SecsPerHour * HoursPerDay;

	typedef enum logic [1:0] {
		UNIT_SEC,
		UNIT_MIN,
		UNIT_HOUR,
		UNIT_DAY
	} unit_t;

	function automatic logic [FactW-1:0] unit_factor(unit_t u);
		logic [FactW-1:0] f;
		case (u)
			UNIT_SEC:  f = FactW'(1);
			UNIT_MIN:  f = FactW'(SecsPerMin);
			UNIT_HOUR: f = FactW'(SecsPerHour);
			UNIT_DAY:  f = FactW'(SecsPerDay);
			default:   f = '0;
		endcase
		return f;
	endfunction

endpackage

// ===== hdl/duration_string_parser.sv =====
// Duration string parser (PnDTnHnMnS): characters in, total seconds out.
// Uses dsp_pkg and the assertion macros in duration_string_parser_assert.svh.
//
//  channel | signals                          | beat
//  --------+----------------------------------+---------------------------------
//  in      | in_valid in_ready character      | one character of the string
//          | is_last                          |
//  out     | out_valid out_ready              | total of one string, after its
//          | total_seconds overflow           | last character
//
// One character per cycle while in_ready is high. The parse state updates in
// the cycle a beat is accepted; the unit scaling (31x17 multiply) and the
// saturating 63-bit add follow in two pipeline stages, stage 1 and stage 2,
// ahead of the result register that raises out_valid. Reset clears all parse
// state, the accumulator and out_valid.
// Input stalls only while a finished total waits in the output register and a
// second last character has reached the accumulator.
`timescale 1ns / 1ps
`include "duration_string_parser_assert.svh"

module duration_string_parser
	import dsp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CharW-1:0]  character,
	input  logic              is_last,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [TotalW-1:0] total_seconds,
	output logic              overflow
);

	// parse state
	logic             first_seen_q, inside_q, skip_q, stopped_q;
	logic [PendW-1:0] pend_q;

	// stage 1: amount to add and its unit
	logic             v_s1, last_s1, povf_s1;
	logic [PendW-1:0] amt_s1;
	unit_t            unit_s1;

	// stage 2: scaled amount
	logic             v_s2, last_s2, povf_s2;
	logic [ProdW-1:0] prod_s2;

	// accumulator and result register
	logic [TotalW-1:0] acc_q;
	logic              acc_ovf_q;
	logic              out_valid_q, overflow_q;
	logic [TotalW-1:0] total_seconds_q;

	logic adv, accept;

	// next parse state
	logic             is_dig, is_dot, is_unit, apply;
	logic [34:0]      push;
	logic             push_ovf;
	logic             nxt_first, nxt_inside, nxt_skip, nxt_stopped, nxt_povf;
	logic [PendW-1:0] nxt_pend, amt;
	unit_t            unit, ch_unit;

	// saturating add
	logic [TotalW:0]   sum;
	logic [TotalW-1:0] acc_nxt;
	logic              acc_ovf_nxt;

	// everything moves unless a second total would overwrite a waiting one
	assign adv      = !(v_s2 && last_s2 && out_valid_q && !out_ready);
	assign in_ready = adv;
	assign accept   = in_valid && adv;

	always_comb begin
		is_dig = character inside {[CH_ZERO:CH_NINE]};
		is_dot = (character == CH_DOT);
		is_unit = 1'b1;
		case (character)
			CH_D:    ch_unit = UNIT_DAY;
			CH_H:    ch_unit = UNIT_HOUR;
			CH_M:    ch_unit = UNIT_MIN;
			CH_S:    ch_unit = UNIT_SEC;
			default: begin
				ch_unit = UNIT_SEC;
				is_unit = 1'b0;
			end
		endcase
	end

	// pend*10 + d; overflow when the result exceeds 2^31-1
	always_comb begin
		logic [34:0] base;
		base     = inside_q ? {4'b0, pend_q} : '0;
		push     = (base << 3) + (base << 1) + {31'b0, character[3:0]};
		push_ovf = |push[34:31];
	end

	always_comb begin
		nxt_first   = first_seen_q;
		nxt_inside  = inside_q;
		nxt_skip    = skip_q;
		nxt_stopped = stopped_q;
		nxt_pend    = pend_q;
		nxt_povf    = 1'b0;
		apply       = 1'b0;
		if (!first_seen_q) begin
			nxt_first = 1'b1;
		end else if (!stopped_q) begin
			if (skip_q) begin
				apply = !is_dig;
			end else if (is_dig) begin
				nxt_inside = 1'b1;
				nxt_pend   = push_ovf ? PEND_MAX : push[PendW-1:0];
				nxt_povf   = push_ovf;
			end else if (inside_q && is_dot) begin
				nxt_inside = 1'b0;
				nxt_skip   = 1'b1;
			end else begin
				apply = 1'b1;
			end
		end
		amt  = '0;
		unit = UNIT_SEC;
		if (apply) begin
			amt        = is_unit ? pend_q : '0;
			unit       = ch_unit;
			nxt_pend   = '0;
			nxt_inside = 1'b0;
			nxt_skip   = 1'b0;
			if (character == CH_S)
				nxt_stopped = 1'b1;
		end else if (is_last && !nxt_stopped) begin
			// end of string counts as seconds
			amt = nxt_pend;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_seen_q <= 1'b0;
			inside_q     <= 1'b0;
			skip_q       <= 1'b0;
			stopped_q    <= 1'b0;
			pend_q       <= '0;
		end else if (accept) begin
			if (is_last) begin
				first_seen_q <= 1'b0;
				inside_q     <= 1'b0;
				skip_q       <= 1'b0;
				stopped_q    <= 1'b0;
				pend_q       <= '0;
			end else begin
				first_seen_q <= nxt_first;
				inside_q     <= nxt_inside;
				skip_q       <= nxt_skip;
				stopped_q    <= nxt_stopped;
				pend_q       <= nxt_pend;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			amt_s1  <= amt;
			unit_s1 <= unit;
			povf_s1 <= nxt_povf;
			last_s1 <= is_last;
			prod_s2 <= {{FactW{1'b0}}, amt_s1} * {{PendW{1'b0}}, unit_factor(unit_s1)};
			povf_s2 <= povf_s1;
			last_s2 <= last_s1;
		end
	end

	always_comb begin
		sum         = {1'b0, acc_q} + {16'b0, prod_s2};
		acc_nxt     = sum[TotalW] ? TOTAL_MAX : sum[TotalW-1:0];
		acc_ovf_nxt = acc_ovf_q || povf_s2 || sum[TotalW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			acc_ovf_q <= 1'b0;
		end else if (adv && v_s2) begin
			if (last_s2) begin
				acc_q     <= '0;
				acc_ovf_q <= 1'b0;
			end else begin
				acc_q     <= acc_nxt;
				acc_ovf_q <= acc_ovf_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && v_s2 && last_s2) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s2 && last_s2) begin
			total_seconds_q <= acc_nxt;
			overflow_q      <= acc_ovf_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign total_seconds = total_seconds_q;
	assign overflow      = overflow_q;

	`DSP_ASSERT_NOW(a_stop_clears_pend, stopped_q, pend_q == '0,
		"pending number not cleared after S")
	`DSP_ASSERT_NOW(a_skip_excl_inside, skip_q, !inside_q,
		"fraction skip and integer digits both active")
	`DSP_ASSERT_NOW(a_stall_only_full, !in_ready, out_valid_q && v_s2 && last_s2,
		"input stalled without a waiting total")
	`DSP_ASSERT_NEXT(a_acc_cleared, adv && v_s2 && last_s2,
		acc_q == '0 && !acc_ovf_q && out_valid_q,
		"accumulator not restarted after end of string")

endmodule

// ===== tb/duration_string_parser_tb.sv =====
// Self-checking bench for duration_string_parser: directed and random strings,
// predicted totals checked beat by beat. Depends on dsp_pkg and the RTL only.
`timescale 1ns / 1ps

module duration_string_parser_tb;
	import dsp_pkg::*;

	localparam logic [CharW-1:0] CH_P    = 16'h0050;
	localparam logic [CharW-1:0] CH_T    = 16'h0054;
	localparam logic [CharW-1:0] CH_CASE = 16'h0020;

	typedef struct packed {
		logic [CharW-1:0] ch;
		logic             last;
		logic             rush;
	} char_beat_t;

	typedef struct packed {
		logic [TotalW-1:0] total;
		logic              ovf;
	} duration_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [CharW-1:0]  character = '0;
	logic              is_last = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [TotalW-1:0] total_seconds;
	logic              overflow;

	char_beat_t       pending_chars[$];
	duration_t        expected_totals[$];
	logic [CharW-1:0] draft[$];

	// predictor state
	logic              p_started, p_in_num, p_frac, p_halted, p_ovf;
	logic [PendW-1:0]  p_pend;
	logic [TotalW-1:0] p_total;

	int errors = 0;
	int chars_accepted = 0;
	int totals_checked = 0;
	int saturated_totals = 0;
	int strings_queued = 0;
	int hold_mark = 32'h7fffffff;

	duration_string_parser i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.character     (character),
		.is_last       (is_last),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.total_seconds (total_seconds),
		.overflow      (overflow)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic is_dec_char(logic [CharW-1:0] ch);
		return ch >= CH_ZERO && ch <= CH_NINE;
	endfunction

	task automatic clear_parse();
		p_started = 1'b0;
		p_in_num  = 1'b0;
		p_frac    = 1'b0;
		p_halted  = 1'b0;
		p_ovf     = 1'b0;
		p_pend    = '0;
		p_total   = '0;
	endtask

	task automatic add_seconds(input logic [TotalW-1:0] amount);
		if (amount > TOTAL_MAX - p_total) begin
			p_total = TOTAL_MAX;
			p_ovf = 1'b1;
		end else begin
			p_total = p_total + amount;
		end
	endtask

	task automatic take_unit(input logic [CharW-1:0] ch);
		logic [TotalW-1:0] n;
		n = TotalW'(p_pend);
		if (ch == CH_D)
			add_seconds(n * TotalW'(SecsPerDay));
		else if (ch == CH_H)
			add_seconds(n * TotalW'(SecsPerHour));
		else if (ch == CH_M)
			add_seconds(n * TotalW'(SecsPerMin));
		else if (ch == CH_S) begin
			add_seconds(n);
			p_halted = 1'b1;
		end
		p_pend = '0;
		p_in_num = 1'b0;
		p_frac = 1'b0;
	endtask

	task automatic predict_char(input logic [CharW-1:0] ch, input logic last);
		logic [PendW-1:0] d;
		d = PendW'(ch - CH_ZERO);
		if (!p_started) begin
			p_started = 1'b1;
		end else if (!p_halted) begin
			if (p_frac) begin
				if (!is_dec_char(ch))
					take_unit(ch);
			end else if (is_dec_char(ch)) begin
				if (!p_in_num) begin
					p_pend = '0;
					p_in_num = 1'b1;
				end
				if (p_pend > (PEND_MAX - d) / PendW'(10)) begin
					p_pend = PEND_MAX;
					p_ovf = 1'b1;
				end else begin
					p_pend = p_pend * PendW'(10) + d;
				end
			end else if (p_in_num && ch == CH_DOT) begin
				p_in_num = 1'b0;
				p_frac = 1'b1;
			end else begin
				take_unit(ch);
			end
		end
		if (last) begin
			if (!p_halted)
				add_seconds(TotalW'(p_pend));
			expected_totals.push_back('{total: p_total, ovf: p_ovf});
			clear_parse();
		end
	endtask

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic logic [CharW-1:0] rand_digit();
		return CharW'($urandom_range(CH_ZERO, CH_NINE));
	endfunction

	function automatic logic [CharW-1:0] noise_char();
		case ($urandom_range(0, 7))
			0: return CharW'($urandom_range(0, 65535));
			1: return 16'h0000;
			2: return 16'hFFFF;
			3: return CH_ZERO - 16'd1;
			4: return CH_NINE + 16'd1;
			5: return CH_CASE | (($urandom_range(0, 1) != 0) ? CH_D : CH_S);
			6: return CH_DOT;
			default: return CharW'($urandom_range(0, 127));
		endcase
	endfunction

	task automatic queue_char(input logic [CharW-1:0] ch, input logic last, input logic rush);
		pending_chars.push_back('{ch: ch, last: last, rush: rush});
		if (last)
			strings_queued++;
	endtask

	task automatic queue_text(input string s, input logic ends, input logic rush);
		for (int i = 0; i < s.len(); i++)
			queue_char(CharW'(s[i]), ends && i == s.len() - 1, rush);
	endtask

	// Builds one string in draft and queues it; returns the beats that matter.
	task automatic queue_random_string(output int live);
		int r;
		int nd;
		int stop_at;
		logic halted;
		draft.delete();
		halted = 1'b0;
		stop_at = 0;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			repeat ($urandom_range(2, 8)) draft.push_back(noise_char());
		end else if (r < 12) begin
			draft.push_back(noise_char());
		end else begin
			draft.push_back(($urandom_range(0, 7) == 0) ? noise_char() : CH_P);
			repeat ($urandom_range(0, 5)) begin
				if (!halted) begin
					if ($urandom_range(0, 3) == 0)
						draft.push_back(CH_T);
					nd = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12)
						: $urandom_range(0, 4);
					repeat (nd) draft.push_back(rand_digit());
					if (nd > 0 && $urandom_range(0, 4) == 0) begin
						draft.push_back(CH_DOT);
						repeat ($urandom_range(0, 3)) draft.push_back(rand_digit());
						// a second dot closes the fraction and drops the number
						if ($urandom_range(0, 5) == 0)
							draft.push_back(CH_DOT);
					end
					case ($urandom_range(0, 9))
						0: draft.push_back(noise_char());
						1, 2, 3: draft.push_back(CH_D);
						4, 5: draft.push_back(CH_H);
						6, 7: draft.push_back(CH_M);
						default: begin
							draft.push_back(CH_S);
							halted = 1'b1;
							stop_at = draft.size();
						end
					endcase
				end
			end
			if (!halted && $urandom_range(0, 2) == 0)
				repeat ($urandom_range(1, 4)) draft.push_back(rand_digit());
			if (halted && $urandom_range(0, 2) == 0)
				repeat ($urandom_range(1, 3)) draft.push_back(noise_char());
		end
		foreach (draft[i])
			queue_char(draft[i], i == draft.size() - 1, 1'b0);
		live = halted ? stop_at : draft.size();
	endtask

	// Sender
	int gap_left = 0;
	int steady_left = 0;

	always @(posedge clk) begin : chars_drive
		char_beat_t beat;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_char(character, is_last);
				chars_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_chars.size() > 0) begin
					beat = pending_chars.pop_front();
					in_valid <= 1'b1;
					character <= beat.ch;
					is_last <= beat.last;
					if (steady_left > 0)
						steady_left--;
					else if ($urandom_range(0, 59) == 0)
						steady_left = $urandom_range(20, 80);
					gap_left = (beat.rush || steady_left > 0) ? 0 : idle_len();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver backpressure, with one long hold-off while input keeps coming
	int stall_left = 0;
	int hold_left = 0;
	logic hold_done = 1'b0;

	always @(posedge clk) begin : ready_drive
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (!hold_done && chars_accepted >= hold_mark) begin
			hold_done = 1'b1;
			hold_left = 300;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				stall_left = idle_len();
		end
	end

	// Result checker
	always @(posedge clk) begin : totals_check
		duration_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_totals.size() == 0) begin
				$error("result beat with no string pending: total_seconds=%0d overflow=%0b",
					total_seconds, overflow);
				errors++;
			end else begin
				want = expected_totals.pop_front();
				totals_checked++;
				if (want.ovf)
					saturated_totals++;
				if (total_seconds !== want.total) begin
					$error("total_seconds: expected %0d, got %0d", want.total, total_seconds);
					errors++;
				end
				if (overflow !== want.ovf) begin
					$error("overflow: expected %0b, got %0b", want.ovf, overflow);
					errors++;
				end
			end
		end
	end

	initial begin
		int live;
		int random_chars;
		clear_parse();

		// single character, first is skipped unchecked
		queue_char(16'hFFFF, 1'b1, 1'b0);
		// all scaled units, end of string closes the number as seconds
		queue_char(16'h0000, 1'b0, 1'b0);
		queue_text("1D2H3M4", 1'b1, 1'b0);
		// unit without digits, S stops, trailing beat ignored
		queue_text("PHS", 1'b0, 1'b0);
		queue_char(16'hFFFF, 1'b1, 1'b0);
		// dot with no digits, dot closing a fraction
		queue_text("P.7.2.3", 1'b1, 1'b0);
		// pending number saturates
		queue_text("P9999999999", 1'b1, 1'b0);
		// largest number in days, back to back
		queue_text("P2147483647D5S", 1'b1, 1'b1);

		hold_mark = pending_chars.size() + 150;
		random_chars = 0;
		while (random_chars < 1350) begin
			queue_random_string(live);
			random_chars += live;
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (pending_chars.size() > 0 || in_valid || expected_totals.size() > 0);
		repeat (20) @(posedge clk);

		$display("Covered %0d strings, %0d character beats, %0d totals checked (%0d saturated),",
			strings_queued, chars_accepted, totals_checked, saturated_totals);
		$display("including fraction, unit-less, oversized-number cases and a long output hold-off.");
		if (errors == 0 && expected_totals.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("Timeout with %0d beats unsent and %0d totals outstanding",
			pending_chars.size(), expected_totals.size());
		$display("TEST FAILED");
		$finish;
	end

endmodule
